### src/v3au_pkg.sv
package v3au_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;               // component width
  localparam int PROD_W    = 2 * DW;           // full product
  localparam int WIDE_W    = PROD_W + 4;       // headroom for sums before saturation
  localparam int NUM_W     = DW + FRAC_BITS;   // scaled dividend / quotient width
  localparam int SQ_STEPS  = DW;               // one root bit per sqrt cell
  localparam int SQ_REM_W  = DW + 4;           // partial remainder of the root
  localparam int DIV_STEPS = NUM_W;            // one quotient bit per divide cell

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_DIV   = 3'd3;
  localparam logic [2:0] OP_LEN   = 3'd4;
  localparam logic [2:0] OP_NORM  = 3'd5;
  localparam logic [2:0] OP_CROSS = 3'd6;
  localparam logic [2:0] OP_DOT   = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  localparam logic signed [WIDE_W-1:0] RND_HALF = WIDE_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [WIDE_W-1:0] WMAX = {{(WIDE_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] WMIN = {{(WIDE_W-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] CMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] CMIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic          ov;
    logic [DW-1:0] val;
  } sat_t;

  // per-item data that rides alongside the sqrt and divide chains
  typedef struct packed {
    logic [2:0]         op;
    logic [2:0]         a_neg;
    logic [2:0]         a_zero;
    logic [2:0][DW-1:0] a_mag;
    logic               s_neg;
    logic               s_zero;
    logic [DW-1:0]      s_mag;
    logic [2:0][DW-1:0] r;
    logic [DW-1:0]      sc;
    logic               ov;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [PROD_W-1:0] val;
    logic [SQ_REM_W-1:0] rem;
    logic [DW-1:0]     root;
  } sq_t;

  typedef struct packed {
    logic [DW-1:0]    rem;
    logic [NUM_W-1:0] nq;   // dividend shifts out on top, quotient in below
  } lane_t;

  typedef struct packed {
    side_t          side;
    logic [DW-1:0]  len;
    logic [DW-1:0]  d;
    lane_t [2:0]    lane;
  } dv_t;

  function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
    sat_t res;
    res.ov  = 1'b0;
    res.val = v[DW-1:0];
    if (v > WMAX) begin
      res.ov  = 1'b1;
      res.val = CMAX;
    end else if (v < WMIN) begin
      res.ov  = 1'b1;
      res.val = CMIN;
    end
    return res;
  endfunction

  // round to nearest, ties toward plus infinity
  function automatic logic signed [WIDE_W-1:0] round_q(input logic signed [WIDE_W-1:0] v);
    return (v + RND_HALF) >>> FRAC_BITS;
  endfunction

endpackage

### src/v3au_if.sv
interface v3au_in_if;
  import v3au_pkg::*;
  logic          valid;
  logic          ready;
  logic [2:0]    op;
  logic [DW-1:0] ax;
  logic [DW-1:0] ay;
  logic [DW-1:0] az;
  logic [DW-1:0] bx;
  logic [DW-1:0] by_comp;
  logic [DW-1:0] bz;
  logic [DW-1:0] scalar_in;
  modport source (output valid, op, ax, ay, az, bx, by_comp, bz, scalar_in, input ready);
  modport sink (input valid, op, ax, ay, az, bx, by_comp, bz, scalar_in, output ready);
endinterface

interface v3au_out_if;
  import v3au_pkg::*;
  logic          valid;
  logic          ready;
  logic [DW-1:0] rx;
  logic [DW-1:0] ry;
  logic [DW-1:0] rz;
  logic [DW-1:0] scalar_out;
  logic [1:0]    status;
  modport source (output valid, rx, ry, rz, scalar_out, status, input ready);
  modport sink (input valid, rx, ry, rz, scalar_out, status, output ready);
endinterface

### src/v3au_front.sv
module v3au_front
  import v3au_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         op,
  input  logic [2:0][DW-1:0] a,
  input  logic [2:0][DW-1:0] b,
  input  logic [DW-1:0]      s,
  output logic               out_valid,
  input  logic               out_ready,
  output sq_t                out_data
);

  // stage 1: products
  logic                       v1_r;
  logic [2:0]                 op1_r;
  logic [2:0][DW-1:0]         a1_r, b1_r;
  logic [DW-1:0]              s1_r;
  logic signed [PROD_W-1:0]   m_r [6];
  logic                       rdy1;
  // stage 2: combine and saturate
  logic                       v2_r;
  sq_t                        d2_r, d2_nxt;
  logic                       rdy2;

  logic signed [DW-1:0] ma [3];
  logic signed [DW-1:0] mb [3];

  assign rdy2     = !v2_r || out_ready;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    ma[0] = (op == OP_CROSS) ? a[1] : a[0];
    ma[1] = (op == OP_CROSS) ? a[2] : a[1];
    ma[2] = a[2];
    case (op)
      OP_SCALE: begin
        mb[0] = s;    mb[1] = s;    mb[2] = s;
      end
      OP_CROSS: begin
        mb[0] = b[2]; mb[1] = b[1]; mb[2] = b[0];
      end
      OP_DOT: begin
        mb[0] = b[0]; mb[1] = b[1]; mb[2] = b[2];
      end
      default: begin
        mb[0] = a[0]; mb[1] = a[1]; mb[2] = a[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
    if (rdy1) begin
      op1_r <= op;
      a1_r  <= a;
      b1_r  <= b;
      s1_r  <= s;
      m_r[0] <= ma[0] * mb[0];
      m_r[1] <= ma[1] * mb[1];
      m_r[2] <= ma[2] * mb[2];
      m_r[3] <= $signed(a[0]) * $signed(b[2]);
      m_r[4] <= $signed(a[0]) * $signed(b[1]);
      m_r[5] <= $signed(a[1]) * $signed(b[0]);
    end
  end

  always_comb begin
    logic signed [WIDE_W-1:0] w [3];
    logic signed [WIDE_W-1:0] wsc;
    sat_t                     sr [3];
    sat_t                     ss;
    for (int i = 0; i < 3; i++) w[i] = '0;
    wsc = '0;
    case (op1_r)
      OP_ADD: begin
        for (int i = 0; i < 3; i++)
          w[i] = WIDE_W'($signed(a1_r[i])) + WIDE_W'($signed(b1_r[i]));
      end
      OP_SUB: begin
        for (int i = 0; i < 3; i++)
          w[i] = WIDE_W'($signed(a1_r[i])) - WIDE_W'($signed(b1_r[i]));
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) w[i] = round_q(WIDE_W'(m_r[i]));
      end
      OP_CROSS: begin
        w[0] = round_q(WIDE_W'(m_r[0]) - WIDE_W'(m_r[1]));
        w[1] = round_q(WIDE_W'(m_r[2]) - WIDE_W'(m_r[3]));
        w[2] = round_q(WIDE_W'(m_r[4]) - WIDE_W'(m_r[5]));
      end
      OP_DOT: begin
        wsc = round_q(WIDE_W'(m_r[0]) + WIDE_W'(m_r[1]) + WIDE_W'(m_r[2]));
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 3; i++) sr[i] = sat32(w[i]);
    ss = sat32(wsc);

    d2_nxt.side.op     = op1_r;
    d2_nxt.side.s_neg  = s1_r[DW-1];
    d2_nxt.side.s_zero = (s1_r == '0);
    d2_nxt.side.s_mag  = s1_r[DW-1] ? (~s1_r + 1'b1) : s1_r;
    for (int i = 0; i < 3; i++) begin
      d2_nxt.side.a_neg[i]  = a1_r[i][DW-1];
      d2_nxt.side.a_zero[i] = (a1_r[i] == '0);
      d2_nxt.side.a_mag[i]  = a1_r[i][DW-1] ? (~a1_r[i] + 1'b1) : a1_r[i];
      d2_nxt.side.r[i]      = sr[i].val;
    end
    d2_nxt.side.sc = ss.val;
    d2_nxt.side.ov = sr[0].ov | sr[1].ov | sr[2].ov | ss.ov;
    d2_nxt.val  = $unsigned(m_r[0]) + $unsigned(m_r[1]) + $unsigned(m_r[2]);
    d2_nxt.rem  = '0;
    d2_nxt.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
    if (rdy2) begin
      d2_r <= d2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = d2_r;

endmodule

### src/v3au_sqrt_cell.sv
module v3au_sqrt_cell
  import v3au_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sq_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output sq_t  out_data
);

  logic v_r;
  sq_t  d_r, d_nxt;

  assign in_ready = !v_r || out_ready;

  // one root bit: bring down two radicand bits, try (root << 2) | 1
  always_comb begin
    logic [SQ_REM_W-1:0] rem2;
    logic [SQ_REM_W-1:0] trial;
    rem2  = {in_data.rem[SQ_REM_W-3:0], in_data.val[PROD_W-1 -: 2]};
    trial = SQ_REM_W'({in_data.root, 2'b01});
    d_nxt      = in_data;
    d_nxt.val  = in_data.val << 2;
    if (rem2 >= trial) begin
      d_nxt.rem  = rem2 - trial;
      d_nxt.root = {in_data.root[DW-2:0], 1'b1};
    end else begin
      d_nxt.rem  = rem2;
      d_nxt.root = {in_data.root[DW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

### src/v3au_div_cell.sv
module v3au_div_cell
  import v3au_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  dv_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output dv_t  out_data
);

  logic v_r;
  dv_t  d_r, d_nxt;

  assign in_ready = !v_r || out_ready;

  // restoring step, one quotient bit per lane
  always_comb begin
    logic [DW:0] t;
    d_nxt = in_data;
    for (int i = 0; i < 3; i++) begin
      t = {in_data.lane[i].rem, in_data.lane[i].nq[NUM_W-1]};
      if (t >= {1'b0, in_data.d}) begin
        d_nxt.lane[i].rem = DW'(t - {1'b0, in_data.d});
        d_nxt.lane[i].nq  = {in_data.lane[i].nq[NUM_W-2:0], 1'b1};
      end else begin
        d_nxt.lane[i].rem = t[DW-1:0];
        d_nxt.lane[i].nq  = {in_data.lane[i].nq[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

### src/v3au_back.sv
module v3au_back
  import v3au_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dv_t                in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0][DW-1:0] r,
  output logic [DW-1:0]      sc,
  output logic [1:0]         status
);

  logic               v_r;
  logic [2:0][DW-1:0] r_r, r_nxt;
  logic [DW-1:0]      sc_r, sc_nxt;
  logic [1:0]         st_r, st_nxt;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    logic                     ov;
    logic                     neg;
    logic signed [WIDE_W-1:0] q;
    sat_t                     sr;
    r_nxt  = in_data.side.r;
    sc_nxt = in_data.side.sc;
    ov     = in_data.side.ov;
    neg    = 1'b0;
    q      = '0;
    sr     = '0;
    st_nxt = ST_OK;
    case (in_data.side.op)
      OP_DIV: begin
        if (in_data.side.s_zero) begin
          st_nxt = ST_DIV0;
          for (int i = 0; i < 3; i++)
            r_nxt[i] = in_data.side.a_neg[i] ? CMIN :
                       (in_data.side.a_zero[i] ? '0 : CMAX);
        end else begin
          for (int i = 0; i < 3; i++) begin
            neg = in_data.side.a_neg[i] ^ in_data.side.s_neg;
            q   = WIDE_W'(in_data.lane[i].nq);
            sr  = sat32(neg ? -q : q);
            r_nxt[i] = sr.val;
            ov = ov | sr.ov;
          end
        end
      end
      OP_NORM: begin
        if (in_data.len == '0) begin
          st_nxt = ST_NULL;
          r_nxt  = '0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            q  = WIDE_W'(in_data.lane[i].nq);
            sr = sat32(in_data.side.a_neg[i] ? -q : q);
            r_nxt[i] = sr.val;
            ov = ov | sr.ov;
          end
        end
      end
      OP_LEN: begin
        sr     = sat32(WIDE_W'(in_data.len));
        sc_nxt = sr.val;
        ov     = ov | sr.ov;
      end
      default: begin
      end
    endcase
    if (st_nxt == ST_OK && ov) st_nxt = ST_SAT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready) begin
      r_r  <= r_nxt;
      sc_r <= sc_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_valid = v_r;
  assign r         = r_r;
  assign sc        = sc_r;
  assign status    = st_r;

endmodule

### src/vec3_arithmetic_unit.sv
// 3D vector arithmetic unit, signed Q16.16 components.
// in_bus  : one beat per item: op, vectors A and B, scalar_in.
// out_bus : one beat per item: rx, ry, rz, scalar_out, status, in input order.
// Ops: add, sub, scale, divide, length, normalize, cross, dot. Every result
// field saturates to 32 bits; status flags overflow, null length on
// normalize of a zero vector, and divide by zero.
// Datapath is a row of cells, every beat walks the full row:
//   2 front stages (products, then combine/round/saturate),
//   32 sqrt cells (one root bit each),
//   48 divide cells (one quotient bit per lane, three lanes),
//   1 output register.
// Every op walks the same row of cells; throughput one beat per cycle while
// out_bus is not stalled.
// Each cell has its own valid and a local ready (empty or moving on), so
// while out_bus is stalled the row keeps filling its bubbles and in_bus
// stays ready until every cell holds a beat.
// Reset (rst_n low, synchronous) empties all cells; no results are lost
// other than those in flight at reset.
module vec3_arithmetic_unit
  import v3au_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  v3au_in_if.sink    in_bus,
  v3au_out_if.source out_bus
);

  logic               f_valid, f_ready;
  sq_t                f_data;

  logic               sq_v   [SQ_STEPS+1];
  logic               sq_rdy [SQ_STEPS+1];
  sq_t                sq_d   [SQ_STEPS+1];

  logic               dv_v   [DIV_STEPS+1];
  logic               dv_rdy [DIV_STEPS+1];
  dv_t                dv_d   [DIV_STEPS+1];

  logic [2:0][DW-1:0] r;

  v3au_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .op        (in_bus.op),
    .a         ({in_bus.az, in_bus.ay, in_bus.ax}),
    .b         ({in_bus.bz, in_bus.by_comp, in_bus.bx}),
    .s         (in_bus.scalar_in),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  assign sq_v[0]  = f_valid;
  assign sq_d[0]  = f_data;
  assign f_ready  = sq_rdy[0];

  // integer square root of the sum of squares
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    v3au_sqrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (sq_v[k]),
      .in_ready  (sq_rdy[k]),
      .in_data   (sq_d[k]),
      .out_valid (sq_v[k+1]),
      .out_ready (sq_rdy[k+1]),
      .out_data  (sq_d[k+1])
    );
  end

  // divider setup: divisor is the length for normalize, |scalar_in| otherwise
  always_comb begin
    dv_d[0].side = sq_d[SQ_STEPS].side;
    dv_d[0].len  = sq_d[SQ_STEPS].root;
    dv_d[0].d    = (sq_d[SQ_STEPS].side.op == OP_NORM) ? sq_d[SQ_STEPS].root
                                                       : sq_d[SQ_STEPS].side.s_mag;
    for (int i = 0; i < 3; i++) begin
      dv_d[0].lane[i].rem = '0;
      dv_d[0].lane[i].nq  = {sq_d[SQ_STEPS].side.a_mag[i], {FRAC_BITS{1'b0}}};
    end
  end
  assign dv_v[0]          = sq_v[SQ_STEPS];
  assign sq_rdy[SQ_STEPS] = dv_rdy[0];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    v3au_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_v[k]),
      .in_ready  (dv_rdy[k]),
      .in_data   (dv_d[k]),
      .out_valid (dv_v[k+1]),
      .out_ready (dv_rdy[k+1]),
      .out_data  (dv_d[k+1])
    );
  end

  v3au_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_v[DIV_STEPS]),
    .in_ready  (dv_rdy[DIV_STEPS]),
    .in_data   (dv_d[DIV_STEPS]),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .r         (r),
    .sc        (out_bus.scalar_out),
    .status    (out_bus.status)
  );

  assign out_bus.rx = r[0];
  assign out_bus.ry = r[1];
  assign out_bus.rz = r[2];

endmodule

### test/v3au_test_if.sv
package v3au_test_pkg;
  import v3au_pkg::*;

  typedef struct packed {
    logic [2:0]    op;
    logic [DW-1:0] ax, ay, az, bx, by_comp, bz, scalar_in;
  } vec_req_t;

  typedef struct packed {
    logic [DW-1:0] rx, ry, rz, scalar_out;
    logic [1:0]    status;
  } vec_res_t;
endpackage

### test/vec3_arithmetic_unit_test.sv
module vec3_arithmetic_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import v3au_pkg::*;
  import v3au_test_pkg::*;

  localparam int LATENCY = 83;
  localparam int N_RAND  = 1800;

  logic clk;
  logic rst_n;

  v3au_in_if  in_bus ();
  v3au_out_if out_bus ();

  vec3_arithmetic_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus.sink),
    .out_bus(out_bus.source)
  );

  // expected results, oldest first
  vec_res_t pending_res[$];
  int       err_cnt;
  bit       quiet;      // no idling in the tail of the run

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Limit: 1825 beats (table plus random) with worst-case gaps and stalls, well under this
  initial begin
    #20ms;
    $display("vec3_arithmetic_unit verification failed");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    err_cnt++;
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // ---------------------------------------------------------------------
  // Predictor, worked in wide signed integers
  // ---------------------------------------------------------------------
  function automatic longint floor_q(input longint v);
    return v >>> FRAC_BITS;    // arithmetic shift is floor
  endfunction

  function automatic longint round_near(input longint v);
    return floor_q(v + (longint'(1) << (FRAC_BITS - 1)));
  endfunction

  function automatic logic [31:0] clamp32(input longint v, inout bit ov);
    if (v > 64'sd2147483647) begin
      ov = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -64'sd2147483648) begin
      ov = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // truncating quotient of num*2^F over den
  function automatic longint fx_div(input longint num, input longint den);
    logic [63:0] n, d, q;
    n = (num < 0 ? -num : num) << FRAC_BITS;
    d = den < 0 ? -den : den;
    q = n / d;
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint root_floor(input logic [63:0] v);
    logic [63:0] res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint len_of(input longint a[3]);
    logic [63:0] s, m;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m = a[i] < 0 ? -a[i] : a[i];
      s += m * m;
    end
    return root_floor(s);
  endfunction

  function automatic vec_res_t vec_predict(input vec_req_t q);
    longint a[3], b[3], s, r[3], sc, lenv, hi, lo, p, ph;
    bit ov;
    logic [1:0] st;
    vec_res_t res;
    a[0] = longint'($signed(q.ax)); a[1] = longint'($signed(q.ay));
    a[2] = longint'($signed(q.az));
    b[0] = longint'($signed(q.bx)); b[1] = longint'($signed(q.by_comp));
    b[2] = longint'($signed(q.bz));
    s  = longint'($signed(q.scalar_in));
    r  = '{0, 0, 0};
    sc = 0;
    ov = 1'b0;
    st = ST_OK;
    case (q.op)
      OP_ADD:   for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
      OP_SUB:   for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
      OP_SCALE: for (int i = 0; i < 3; i++) r[i] = round_near(a[i] * s);
      OP_DIV: begin
        if (s == 0) begin
          st = ST_DIV0;
          for (int i = 0; i < 3; i++)
            r[i] = a[i] > 0 ? 64'sd2147483647 : (a[i] < 0 ? -64'sd2147483648 : 64'sd0);
        end else begin
          for (int i = 0; i < 3; i++) r[i] = fx_div(a[i], s);
        end
      end
      OP_LEN: sc = len_of(a);
      OP_NORM: begin
        lenv = len_of(a);
        if (lenv == 0) st = ST_NULL;
        else for (int i = 0; i < 3; i++) r[i] = fx_div(a[i], lenv);
      end
      OP_CROSS: begin
        r[0] = round_near(a[1] * b[2] - a[2] * b[1]);
        r[1] = round_near(a[2] * b[0] - a[0] * b[2]);
        r[2] = round_near(a[0] * b[1] - a[1] * b[0]);
      end
      default: begin
        // split each product so the sum cannot wrap 64 bits
        hi = 0;
        lo = 0;
        for (int i = 0; i < 3; i++) begin
          p  = a[i] * b[i];
          ph = floor_q(p);
          hi += ph;
          lo += p - (ph << FRAC_BITS);
        end
        sc = hi + round_near(lo);
      end
    endcase
    res.rx = clamp32(r[0], ov);
    res.ry = clamp32(r[1], ov);
    res.rz = clamp32(r[2], ov);
    res.scalar_out = clamp32(sc, ov);
    res.status = (st == ST_OK && ov) ? ST_SAT : st;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table: hand-typed expectation where it is obvious
  // ---------------------------------------------------------------------
  typedef struct {
    vec_req_t req;
    bit       typed;
    vec_res_t res;
  } dir_row_t;

  localparam logic [31:0] MX = 32'h7fff_ffff;
  localparam logic [31:0] MN = 32'h8000_0000;
  localparam logic [31:0] ONE = 32'h0001_0000;

  dir_row_t dir_tab[] = '{
    // overflow on add and sub
    '{'{OP_ADD, MX, MN, 0, ONE, MN, 0, 0}, 1, '{MX, MN, 0, 0, ST_SAT}},
    '{'{OP_SUB, MN, MX, 0, ONE, MN, 0, 0}, 1, '{MN, MX, 0, 0, ST_SAT}},
    '{'{OP_ADD, 1, 2, 3, 4, 5, 6, 0}, 1, '{5, 7, 9, 0, ST_OK}},
    // scale by one, by extremes
    '{'{OP_SCALE, ONE, MN, MX, 0, 0, 0, ONE}, 1, '{ONE, MN, MX, 0, ST_OK}},
    '{'{OP_SCALE, MX, MN, 32'hffff_ffff, 0, 0, 0, MX}, 0, '0},
    '{'{OP_SCALE, MN, MN, 1, 0, 0, 0, MN}, 0, '0},
    '{'{OP_SCALE, 32'h0000_8000, 32'hffff_8000, 1, 0, 0, 0, 1}, 0, '0},
    // divide by zero (saturated sign, zero stays zero), by one, by extremes
    '{'{OP_DIV, 5, 32'hffff_fff0, 0, 0, 0, 0, 0}, 1, '{MX, MN, 0, 0, ST_DIV0}},
    '{'{OP_DIV, MX, MN, 7, 0, 0, 0, ONE}, 1, '{MX, MN, 7, 0, ST_OK}},
    '{'{OP_DIV, MX, MN, 1, 0, 0, 0, 1}, 0, '0},
    '{'{OP_DIV, MN, MX, 32'hffff_ffff, 0, 0, 0, MN}, 0, '0},
    '{'{OP_DIV, MN, 3, 3, 0, 0, 0, 32'hffff_ffff}, 0, '0},
    // length
    '{'{OP_LEN, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, ST_OK}},
    '{'{OP_LEN, MN, MN, MN, 0, 0, 0, 0}, 0, '0},
    '{'{OP_LEN, 3, 4, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 5, ST_OK}},
    // normalize: null vector, tiny vector, extremes
    '{'{OP_NORM, 0, 0, 0, MX, MX, MX, MX}, 1, '{0, 0, 0, 0, ST_NULL}},
    '{'{OP_NORM, 0, 0, 1, 0, 0, 0, 0}, 1, '{0, 0, ONE, 0, ST_OK}},
    '{'{OP_NORM, MN, MX, MN, 0, 0, 0, 0}, 0, '0},
    // cross
    '{'{OP_CROSS, ONE, 0, 0, 0, ONE, 0, 0}, 1, '{0, 0, ONE, 0, ST_OK}},
    '{'{OP_CROSS, MN, MX, MN, MX, MN, MX, 0}, 0, '0},
    '{'{OP_CROSS, MN, MN, MN, MN, MN, MN, 0}, 0, '0},
    // dot
    '{'{OP_DOT, ONE, ONE, ONE, ONE, ONE, ONE, 0}, 1, '{0, 0, 0, 32'h0003_0000, ST_OK}},
    '{'{OP_DOT, MN, MN, MN, MN, MN, MN, 0}, 1, '{0, 0, 0, MX, ST_SAT}},
    '{'{OP_DOT, MN, MX, 1, MX, MN, 1, 0}, 0, '0},
    '{'{OP_DOT, 32'h0000_8000, 0, 0, 1, 0, 0, 0}, 0, '0}
  };

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 7))
      0:       return MX;
      1:       return MN;
      2:       return $urandom_range(0, 3) - 1;
      3, 4:    return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic vec_req_t rand_req();
    vec_req_t q;
    q.op = 3'($urandom_range(0, 7));
    q.ax = rand_comp(); q.ay = rand_comp(); q.az = rand_comp();
    q.bx = rand_comp(); q.by_comp = rand_comp(); q.bz = rand_comp();
    q.scalar_in = rand_comp();
    if ($urandom_range(0, 15) == 0) q.scalar_in = '0;
    if (q.op == OP_NORM && $urandom_range(0, 9) == 0) {q.ax, q.ay, q.az} = '0;
    return q;
  endfunction

  // expectation is queued at the accepting edge
  task automatic send_beat(input vec_req_t q, input vec_res_t want);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.op        <= q.op;
    in_bus.ax        <= q.ax;
    in_bus.ay        <= q.ay;
    in_bus.az        <= q.az;
    in_bus.bx        <= q.bx;
    in_bus.by_comp   <= q.by_comp;
    in_bus.bz        <= q.bz;
    in_bus.scalar_in <= q.scalar_in;
    do @(posedge clk); while (!in_bus.ready);
    pending_res.push_back(want);
  endtask

  task automatic issue(input vec_req_t q, input bit typed, input vec_res_t want);
    vec_res_t p;
    p = vec_predict(q);
    if (typed && p !== want)
      report("table row vs predictor", p.rx ^ want.rx, {30'd0, p.status ^ want.status});
    send_beat(q, typed ? want : p);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random stall bursts, then compare each beat
  // ---------------------------------------------------------------------
  int stall_left;

  always @(posedge clk) begin
    vec_res_t w;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_res.size() == 0) begin
          report("unexpected beat", out_bus.rx, 32'd0);
        end else begin
          w = pending_res.pop_front();
          if (out_bus.rx !== w.rx) report("rx", out_bus.rx, w.rx);
          if (out_bus.ry !== w.ry) report("ry", out_bus.ry, w.ry);
          if (out_bus.rz !== w.rz) report("rz", out_bus.rz, w.rz);
          if (out_bus.scalar_out !== w.scalar_out)
            report("scalar_out", out_bus.scalar_out, w.scalar_out);
          if (out_bus.status !== w.status)
            report("status", 32'(out_bus.status), 32'(w.status));
        end
      end
      if (stall_left > 0) stall_left--;
      else if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 15);
      out_bus.ready <= (stall_left == 0);
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int wait_cyc;
    rst_n        = 1'b0;
    in_bus.valid = 1'b0;
    {in_bus.op, in_bus.ax, in_bus.ay, in_bus.az} = '0;
    {in_bus.bx, in_bus.by_comp, in_bus.bz, in_bus.scalar_in} = '0;
    out_bus.ready = 1'b0;
    err_cnt = 0;
    quiet   = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) issue(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);
    for (int n = 0; n < N_RAND; n++) begin
      if (n == N_RAND - 200) quiet = 1'b1;
      issue(rand_req(), 1'b0, '0);
    end
    in_bus.valid <= 1'b0;

    wait_cyc = 0;
    while (pending_res.size() != 0 && wait_cyc < 20000) begin
      @(posedge clk);
      wait_cyc++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (err_cnt == 0 && pending_res.size() == 0)
      $display("vec3_arithmetic_unit verification clean");
    else
      $display("vec3_arithmetic_unit verification failed");
    $finish;
  end

endmodule
